// File: rtl/gae_pkg.sv
// Shared types and constants for the generalized advantage estimate core.
// No dependencies; imported by generalized_advantage_estimate_core.
`default_nettype none

package gae_pkg;

  localparam int MAX_STEPS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  localparam logic [15:0] DISCOUNT_RESET  = 16'd32440;
  localparam logic [15:0] SMOOTHING_RESET = 16'd31130;

  localparam logic REG_DISCOUNT  = 1'b0;
  localparam logic REG_SMOOTHING = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_GAIN,
    ST_GAIN_SAVE,
    ST_READ,
    ST_MUL_VALUE,
    ST_MUL_ADV,
    ST_SUM,
    ST_EMIT
  } gae_state_t;

endpackage

`default_nettype wire

// File: rtl/generalized_advantage_estimate_core.sv
// Top level of the generalized advantage estimate core: trajectory store,
// backward pass sequencer and one shared 18x32 signed multiplier.
// Depends on gae_pkg.
//
//   Channel   Handshake               Payload
//   item      item_valid/item_ready   reward, value, end_of_trajectory
//   result    result_valid/result_ready advantage, step_index, last_of_run, overflow
//   config    APB psel/penable/pwrite paddr, pwdata, prdata
//
// Each item is taken in the load state. An item marked as the end of the trajectory
// starts a pass: the gain is formed once, then each stored step is read through
// the registered memory port, goes through the shared multiplier twice, is summed
// and emitted. No item is taken during a pass, and a stalled result holds
// the sequencer. Synchronous reset clears the step count, the drop flag and
// the sequencer and loads the factor defaults; the store itself is not cleared.
`default_nettype none

module generalized_advantage_estimate_core
  import gae_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic signed [15:0] reward,
  input  wire logic signed [15:0] value,
  input  wire logic               end_of_trajectory,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic signed [31:0]      advantage,
  output logic [5:0]              step_index,
  output logic                    last_of_run,
  output logic                    overflow,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  gae_state_t state, state_next;

  logic [15:0]             discount;
  logic [15:0]             smoothing;
  logic [CNT_W-1:0]        step_count;
  logic                    dropped;
  logic [IDX_W-1:0]        idx;
  logic [16:0]             gain;
  logic signed [15:0]      next_value;
  logic signed [31:0]      prev_adv;
  logic signed [18:0]      delta;
  logic signed [31:0]      adv;
  logic signed [49:0]      prod;
  logic [31:0]             rdata;
  logic [31:0]             traj_mem [MAX_STEPS];

  logic signed [17:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic                    item_take;
  logic                    store_room;
  logic                    result_take;
  logic [CNT_W-1:0]        count_after;
  logic signed [18:0]      delta_calc;
  logic signed [35:0]      sum;
  logic signed [31:0]      sum_sat;
  logic                    cfg_write;

  function automatic logic signed [15:0] reward_of(input logic [31:0] w);
    return $signed(w[31:16]);
  endfunction

  function automatic logic signed [15:0] value_of(input logic [31:0] w);
    return $signed(w[15:0]);
  endfunction

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign prdata      = (paddr[2] == REG_SMOOTHING) ? {16'b0, smoothing} : {16'b0, discount};

  assign item_take   = item_valid && item_ready;
  assign result_take = result_valid && result_ready;
  assign store_room  = step_count < CNT_W'(MAX_STEPS);
  assign count_after = store_room ? step_count + CNT_W'(1) : step_count;

  assign delta_calc = 19'(reward_of(rdata)) + 19'($signed(prod[32:15]))
                    - 19'(value_of(rdata));
  assign sum        = 36'(delta) + 36'($signed(prod[49:15]));

  always_comb begin
    if (sum > 36'sd2147483647) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum < -36'sd2147483648) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (item_take && end_of_trajectory) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN:      state_next = ST_GAIN_SAVE;
      ST_GAIN_SAVE: state_next = ST_READ;
      ST_READ:      state_next = ST_MUL_VALUE;
      ST_MUL_VALUE: state_next = ST_MUL_ADV;
      ST_MUL_ADV:   state_next = ST_SUM;
      ST_SUM:       state_next = ST_EMIT;
      ST_EMIT: begin
        if (result_ready) begin
          state_next = (idx == '0) ? ST_LOAD : ST_READ;
        end
      end
      default:      state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    result_valid = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      ST_LOAD: item_ready = 1'b1;
      ST_GAIN: begin
        mul_a = $signed({2'b0, discount});
        mul_b = $signed({16'b0, smoothing});
      end
      ST_MUL_VALUE: begin
        mul_a = $signed({2'b0, discount});
        mul_b = 32'(next_value);
      end
      ST_MUL_ADV: begin
        mul_a = $signed({1'b0, gain});
        mul_b = prev_adv;
      end
      ST_EMIT: result_valid = 1'b1;
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      discount   <= DISCOUNT_RESET;
      smoothing  <= SMOOTHING_RESET;
      step_count <= '0;
      dropped    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (paddr[2] == REG_DISCOUNT) begin
          discount <= pwdata[15:0];
        end else begin
          smoothing <= pwdata[15:0];
        end
      end
      if (item_take) begin
        step_count <= count_after;
        if (!store_room) begin
          dropped <= 1'b1;
        end
      end
      if (result_take && idx == '0) begin
        step_count <= '0;
        dropped    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    rdata <= traj_mem[idx];
    if (item_take && store_room) begin
      traj_mem[step_count[IDX_W-1:0]] <= {reward, value};
    end
    if (item_take && end_of_trajectory) begin
      idx        <= IDX_W'(count_after - CNT_W'(1));
      next_value <= '0;
      prev_adv   <= '0;
    end
    if (state == ST_GAIN_SAVE) begin
      gain <= prod[31:15];
    end
    if (state == ST_MUL_ADV) begin
      delta <= delta_calc;
    end
    if (state == ST_SUM) begin
      adv <= sum_sat;
    end
    if (result_take) begin
      prev_adv   <= adv;
      next_value <= value_of(rdata);
      if (idx != '0) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  assign advantage   = adv;
  assign step_index  = idx;
  assign last_of_run = (idx == '0);
  assign overflow    = dropped;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("Result pending while items are accepted.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    step_count <= CNT_W'(MAX_STEPS))
    else $error("Step count beyond capacity.");

  a_pass_clears: assert property (@(posedge clk) disable iff (rst)
    (result_take && last_of_run) |=> (step_count == '0 && !dropped && item_ready))
    else $error("Trajectory state not cleared after the last result.");

  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    (item_take && !end_of_trajectory && store_room) |=>
      (step_count == $past(step_count) + CNT_W'(1)))
    else $error("Stored item not counted.");

endmodule

`default_nettype wire

// File: dv/gae_advantage_checker.sv
// Checker for the generalized advantage estimate core: watches the config,
// item and result channels, predicts every result and compares advantage, step index, last flag and overflow.
// Depends on gae_pkg.
`timescale 1ns / 100ps

module gae_advantage_checker
  import gae_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic signed [15:0] reward,
  input  logic signed [15:0] value,
  input  logic               end_of_trajectory,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic signed [31:0] advantage,
  input  logic [5:0]         step_index,
  input  logic               last_of_run,
  input  logic               overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  localparam longint ADV_HI = 64'sd2147483647;
  localparam longint ADV_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] adv;
    logic [5:0]         idx;
    logic               last;
    logic               ovf;
  } adv_result_t;

  logic signed [15:0] reward_mem [MAX_STEPS];
  logic signed [15:0] value_mem  [MAX_STEPS];
  int                 stored;
  logic               dropped;
  logic [15:0]        discount_q;
  logic [15:0]        smoothing_q;
  adv_result_t        expected_advantages [$];
  adv_result_t        want;

  task automatic report_mismatch(input string field, input longint got, input longint exp_val);
    $display("%0t: %s is %0d, predicted %0d", $realtime, field, got, exp_val);
    errors++;
  endtask

  // Stores one step and, on the end mark, predicts the whole backward pass.
  function automatic void take_step(logic signed [15:0] r, logic signed [15:0] v, logic eot);
    longint      disc;
    longint      gain;
    longint      next_v;
    longint      prev;
    longint      delta;
    longint      adv;
    int          i;
    adv_result_t res;
    if (stored < MAX_STEPS) begin
      reward_mem[stored] = r;
      value_mem[stored]  = v;
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (!eot) return;
    disc = discount_q;
    gain = (disc * longint'(smoothing_q)) >>> 15;
    prev = 0;
    for (i = stored - 1; i >= 0; i--) begin
      next_v = (i + 1 < stored) ? longint'(value_mem[i + 1]) : 0;
      delta  = longint'(reward_mem[i]) + ((disc * next_v) >>> 15) - longint'(value_mem[i]);
      adv    = delta + ((gain * prev) >>> 15);
      if (adv > ADV_HI) adv = ADV_HI;
      if (adv < ADV_LO) adv = ADV_LO;
      prev     = adv;
      res.adv  = adv[31:0];
      res.idx  = 6'(i);
      res.last = (i == 0);
      res.ovf  = dropped;
      expected_advantages.insert(expected_advantages.size(), res);
    end
    stored  = 0;
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stored      = 0;
      dropped     = 1'b0;
      discount_q  = DISCOUNT_RESET;
      smoothing_q = SMOOTHING_RESET;
      expected_advantages.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_DISCOUNT, 2'b00}) begin
          discount_q = pwdata[15:0];
        end else if (paddr == {REG_SMOOTHING, 2'b00}) begin
          smoothing_q = pwdata[15:0];
        end
      end
      if (item_valid && item_ready) begin
        take_step(reward, value, end_of_trajectory);
      end
      if (result_valid && result_ready) begin
        if (expected_advantages.size() == 0) begin
          report_mismatch("unexpected advantage", advantage, 0);
        end else begin
          want = expected_advantages.pop_front();
          if (advantage !== want.adv) report_mismatch("advantage", advantage, want.adv);
          if (step_index !== want.idx) report_mismatch("step_index", step_index, want.idx);
          if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
          if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
        end
      end
      pending <= expected_advantages.size();
    end
  end

endmodule

// File: dv/generalized_advantage_estimate_core_tb.sv
// Testbench top for the generalized advantage estimate core: clock, reset,
// config writes, trajectory stimulus and the verdict.
// Depends on gae_pkg, generalized_advantage_estimate_core and gae_advantage_checker.
`timescale 1ns / 100ps

module generalized_advantage_estimate_core_tb;
  import gae_pkg::*;

  localparam int LIMIT        = 1000000;
  localparam int DRAIN_CYCLES = 16;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic signed [15:0] reward;
  logic signed [15:0] value;
  logic               end_of_trajectory;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [31:0] advantage;
  logic [5:0]         step_index;
  logic               last_of_run;
  logic               overflow;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               calm;
  int                 errors;
  int                 pending;
  int                 cycle_count;

  generalized_advantage_estimate_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .reward(reward), .value(value), .end_of_trajectory(end_of_trajectory),
    .result_valid(result_valid), .result_ready(result_ready),
    .advantage(advantage), .step_index(step_index),
    .last_of_run(last_of_run), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gae_advantage_checker adv_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .reward(reward), .value(value), .end_of_trajectory(end_of_trajectory),
    .result_valid(result_valid), .result_ready(result_ready),
    .advantage(advantage), .step_index(step_index),
    .last_of_run(last_of_run), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    result_ready <= calm || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("generalized_advantage_estimate_core: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] pick_q78();
    case ($urandom_range(9))
      0: pick_q78 = 16'h7fff;
      1: pick_q78 = 16'h8000;
      2: pick_q78 = 16'h0000;
      default: pick_q78 = 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [15:0] r, input logic [15:0] v, input logic eot);
    while (!calm && $urandom_range(99) < 6) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid        <= 1'b1;
    reward            <= r;
    value             <= v;
    end_of_trajectory <= eot;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic send_trajectory(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_item(pick_q78(), pick_q78(), k == len - 1);
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int          p;
    int          k;
    int          phase_items;
    int          len;
    logic [15:0] disc_w;
    logic [15:0] smooth_w;
    rst               = 1'b1;
    item_valid        = 1'b0;
    reward            = '0;
    value             = '0;
    end_of_trajectory = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    calm              = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(16'h7fff, 16'h8000, 1'b1);
    send_item(16'h8000, 16'h7fff, 1'b1);
    send_item(16'h7fff, 16'h7fff, 1'b0);
    send_item(16'h8000, 16'h8000, 1'b1);
    drain();

    write_reg(REG_DISCOUNT, 16'd0);
    write_reg(REG_SMOOTHING, 16'd0);
    send_item(16'h0001, 16'hffff, 1'b0);
    send_item(16'h8000, 16'h7fff, 1'b1);
    drain();

    // Factors near 2.0 drive the running advantage into both saturation limits.
    write_reg(REG_DISCOUNT, 16'hffff);
    write_reg(REG_SMOOTHING, 16'hffff);
    for (k = 0; k < 10; k++) send_item(16'h7fff, 16'h0000, k == 9);
    for (k = 0; k < 9; k++) send_item(16'h8000, 16'h0000, k == 8);
    drain();

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin disc_w = 16'd32768; smooth_w = 16'd32768; end
        1: begin disc_w = 16'd0;     smooth_w = 16'hffff;  end
        2: begin disc_w = 16'hffff;  smooth_w = 16'd0;     end
        3: begin
          disc_w   = 16'($urandom_range(32768));
          smooth_w = 16'($urandom_range(32768));
        end
        default: begin disc_w = 16'($urandom); smooth_w = 16'($urandom); end
      endcase
      write_reg(REG_DISCOUNT, disc_w);
      write_reg(REG_SMOOTHING, smooth_w);
      calm <= (p == 2);
      phase_items = 0;
      while (phase_items < 12) begin
        // One trajectory overruns the store by two items, the second of which
        // carries the end mark.
        if (phase_items == 0 && p == 2) len = MAX_STEPS + 2;
        else if ($urandom_range(11) == 0) len = $urandom_range(24, 9);
        else len = $urandom_range(8, 1);
        send_trajectory(len);
        phase_items += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("generalized_advantage_estimate_core: match");
    end else begin
      $display("generalized_advantage_estimate_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gae_pkg.sv
rtl/generalized_advantage_estimate_core.sv
dv/gae_advantage_checker.sv
dv/generalized_advantage_estimate_core_tb.sv
